// ===== rtl/chip8_cpu_core_macros.svh =====
// Assertion macros for the CHIP-8 core checker.
// The user of a macro provides signals named clk and rst in its scope.
`ifndef CHIP8_CPU_CORE_MACROS_SVH
`define CHIP8_CPU_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define C8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define C8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c8_pkg.sv =====
// Shared types, constants and the font table of the CHIP-8 core.
// Used by the interfaces, the ALU, the RAM users, the top level and the checker.
package c8_pkg;

  localparam int ADDR_W          = 12;
  localparam int MEM_BYTES       = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam int FONT_BYTES      = 80;
  localparam logic [ADDR_W-1:0] FONT_BASE  = 12'h050;
  localparam logic [ADDR_W-1:0] PROG_START = 12'h200;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EXEC  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_UNKNOWN = 2'd1,
    FAULT_OVER    = 2'd2,
    FAULT_UNDER   = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START, S_RDMEM, S_RDPIX, S_FHI, S_FLO, S_RVX, S_RVY,
    S_EXEC, S_RET, S_VF, S_CLS, S_DR_RD, S_DR_FB, S_DR_WR, S_BCD_H, S_BCD_T,
    S_BCD_O, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_FIN, S_DONE
  } state_t;

  // Reset contents of program memory: the font glyphs, zero elsewhere.
  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && off < ADDR_W'(FONT_BYTES)) begin
      return FONT[off[6:0]];
    end
    return 8'h00;
  endfunction

endpackage

// ===== rtl/c8_req_if.sv =====
// Request channel of the CHIP-8 core: valid/ready plus the item fields.
// Depends on c8_pkg.
interface c8_req_if import c8_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] address;
  logic [7:0]        data;
  logic [15:0]       keys;
  logic [7:0]        random_byte;

  modport source(output valid, opcode, address, data, keys, random_byte, input ready);
  modport sink(input valid, opcode, address, data, keys, random_byte, output ready);
endinterface

// ===== rtl/c8_rsp_if.sv =====
// Result channel of the CHIP-8 core: valid/ready plus the result fields.
// Depends on c8_pkg.
interface c8_rsp_if import c8_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index_reg;
  logic              draw_flag;
  logic              sound_on;
  logic              waiting_key;
  logic [7:0]        read_value;
  logic [1:0]        fault;

  modport source(output valid, pc, index_reg, draw_flag, sound_on, waiting_key,
                 read_value, fault, input ready);
  modport sink(input valid, pc, index_reg, draw_flag, sound_on, waiting_key,
               read_value, fault, output ready);
endinterface

// ===== rtl/c8_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/c8_alu.sv =====
// Shared 8-bit ALU of the CHIP-8 core: logic, add, subtract, shifts, equality.
// Depends on c8_pkg.
module c8_alu import c8_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [8:0] sum;

  always_comb begin
    sum      = {1'b0, req.a} + {1'b0, req.b};
    rsp.eq   = (req.a == req.b);
    rsp.flag = 1'b0;
    case (req.op)
      ALU_MOV: rsp.res = req.b;
      ALU_OR:  rsp.res = req.a | req.b;
      ALU_AND: rsp.res = req.a & req.b;
      ALU_XOR: rsp.res = req.a ^ req.b;
      ALU_ADD: begin
        rsp.res  = sum[7:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.res  = req.a - req.b;
        rsp.flag = (req.a >= req.b);
      end
      ALU_SHR: begin
        rsp.res  = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      ALU_SHL: begin
        rsp.res  = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: rsp.res = 8'h00;
    endcase
  end

endmodule

// ===== rtl/chip8_cpu_core.sv =====
// CHIP-8 core. Request kinds: load, memory or pixel read, and execute, which covers plain
// instructions, register flag ops, clear screen, draw (one pass per sprite row), BCD and
// FX55/FX65 (one pass per register). One request at a time: the next one is taken only
// after the result is raised, and a result is raised only once the previous one is taken.
// Synchronous reset runs a pass over every memory address that loads the font and clears memory,
// framebuffer and registers; no request is taken until it ends.
module chip8_cpu_core import c8_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst,
  c8_req_if.sink  req,
  c8_rsp_if.source rsp
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int MAW = $clog2(MEM_BYTES);
  localparam int RAW = $clog2(SCREEN_H);
  localparam int CAW = $clog2(SCREEN_W);

  state_t state, state_next;

  logic [MAW-1:0]    clr_cnt;
  kind_t             kind;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        data_r;
  logic [15:0]       keys_r;
  logic [7:0]        rnd_r;
  logic [15:0]       op;
  logic [7:0]        vx, vy, tmp;
  logic [4:0]        cnt;
  logic [3:0]        dig;
  logic              hit;
  logic [ADDR_W-1:0] pc, idx;
  logic [SPW-1:0]    sp;
  logic [7:0]        dt, st;
  logic              drew, waiting;
  fault_t            fault;
  logic [7:0]        rv;

  // Memory ports.
  logic              mem_we;
  logic [MAW-1:0]    mem_wa, mem_ra;
  logic [7:0]        mem_wd, mem_q;
  logic              rf_we;
  logic [3:0]        rf_wa, rf_ra;
  logic [7:0]        rf_wd, rf_q;
  logic              fb_we;
  logic [RAW-1:0]    fb_wa, fb_ra;
  logic [SCREEN_W-1:0] fb_wd, fb_q;
  logic              stk_we;
  logic [SAW-1:0]    stk_wa, stk_ra;
  logic [ADDR_W-1:0] stk_wd, stk_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [3:0]          x, n;
  logic [7:0]          nn;
  logic [ADDR_W-1:0]   nnn, pc2, pc4, idx_cnt;
  logic [SPW-1:0]      sp_dec;
  logic                key_bit, key_any;
  logic [3:0]          key_low;
  logic [SCREEN_W-1:0] spr_line, spr_mask;
  logic [RAW-1:0]      dr_row;
  logic                accept;

  assign x       = op[11:8];
  assign n       = op[3:0];
  assign nn      = op[7:0];
  assign nnn     = op[11:0];
  assign pc2     = pc + ADDR_W'(2);
  assign pc4     = pc + ADDR_W'(4);
  assign idx_cnt = idx + ADDR_W'(cnt);
  assign sp_dec  = sp - SPW'(1);
  assign key_bit = keys_r[vx[3:0]];
  assign key_any = |keys_r;
  assign dr_row  = vy[RAW-1:0] + cnt[RAW-1:0];
  assign accept  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    key_low = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_r[i]) key_low = 4'(i);
    end
  end

  // Sprite row placed at column vx mod 64, wrapping at the right edge.
  always_comb begin
    spr_line = '0;
    for (int i = 0; i < 8; i++) begin
      spr_line[i] = tmp[7-i];
    end
    spr_mask = (spr_line << vx[CAW-1:0]) |
               (spr_line >> ((CAW+1)'(SCREEN_W) - {1'b0, vx[CAW-1:0]}));
  end

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_q)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_q)
  );
  c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_wa), .wdata(fb_wd), .raddr(fb_ra), .rdata(fb_q)
  );
  c8_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_q)
  );

  c8_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (clr_cnt == MAW'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_START;
      S_START: begin
        case (kind)
          KIND_LOAD:  state_next = S_DONE;
          KIND_READ:  state_next = S_RDMEM;
          KIND_PIXEL: state_next = S_RDPIX;
          default:    state_next = S_FHI;
        endcase
      end
      S_RDMEM, S_RDPIX: state_next = S_DONE;
      S_FHI:   state_next = S_FLO;
      S_FLO:   state_next = S_RVX;
      S_RVX:   state_next = S_RVY;
      S_RVY:   state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_FIN;
        case (op[15:12])
          4'h0: begin
            if (op == 16'h00E0) state_next = S_CLS;
            else if (op == 16'h00EE && sp != '0) state_next = S_RET;
          end
          4'h8: if (n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) state_next = S_VF;
          4'hD: state_next = S_DR_RD;
          4'hF: begin
            if (nn == 8'h33) state_next = S_BCD_H;
            else if (nn == 8'h55) state_next = S_ST_RD;
            else if (nn == 8'h65) state_next = S_LD_RD;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_RET, S_VF: state_next = S_FIN;
      S_CLS:   if (cnt == 5'(SCREEN_H - 1)) state_next = S_FIN;
      S_DR_RD: state_next = (cnt == {1'b0, n}) ? S_FIN : S_DR_FB;
      S_DR_FB: state_next = S_DR_WR;
      S_DR_WR: state_next = S_DR_RD;
      S_BCD_H: if (!alu_rsp.flag) state_next = S_BCD_T;
      S_BCD_T: if (!alu_rsp.flag) state_next = S_BCD_O;
      S_BCD_O: state_next = S_FIN;
      S_ST_RD: state_next = S_ST_WR;
      S_ST_WR: state_next = (cnt[3:0] == x) ? S_FIN : S_ST_RD;
      S_LD_RD: state_next = S_LD_WR;
      S_LD_WR: state_next = (cnt[3:0] == x) ? S_FIN : S_LD_RD;
      S_FIN:   state_next = S_DONE;
      S_DONE:  if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port and ALU control.
  always_comb begin
    mem_we = 1'b0; mem_wa = idx; mem_wd = 8'h00; mem_ra = pc;
    rf_we = 1'b0; rf_wa = x; rf_wd = 8'h00; rf_ra = x;
    fb_we = 1'b0; fb_wa = dr_row; fb_wd = '0; fb_ra = dr_row;
    stk_we = 1'b0; stk_wa = sp[SAW-1:0]; stk_wd = pc2; stk_ra = sp_dec[SAW-1:0];
    alu_req.op = ALU_XOR; alu_req.a = vx; alu_req.b = nn;
    case (state)
      S_CLR: begin
        mem_we = 1'b1; mem_wa = clr_cnt; mem_wd = font_byte(clr_cnt);
        rf_we = 1'b1; rf_wa = clr_cnt[3:0];
        fb_we = 1'b1; fb_wa = clr_cnt[RAW-1:0];
      end
      S_START: begin
        case (kind)
          KIND_LOAD:  begin mem_we = 1'b1; mem_wa = addr_r; mem_wd = data_r; end
          KIND_READ:  mem_ra = addr_r;
          KIND_PIXEL: fb_ra = addr_r[CAW+RAW-1:CAW];
          default:    mem_ra = pc;
        endcase
      end
      S_FHI: mem_ra = pc + ADDR_W'(1);
      S_FLO: rf_ra = (op[15:12] == 4'hB) ? 4'h0 : x;
      S_RVX: rf_ra = op[7:4];
      S_EXEC: begin
        case (op[15:12])
          4'h2: stk_we = (sp < SPW'(STACK_DEPTH));
          4'h5, 4'h9: alu_req.b = vy;
          4'h6: begin rf_we = 1'b1; rf_wd = nn; end
          4'h7: begin
            alu_req.op = ALU_ADD;
            rf_we = 1'b1; rf_wd = alu_rsp.res;
          end
          4'h8: begin
            alu_req.b = vy;
            rf_we = 1'b1; rf_wd = alu_rsp.res;
            case (n)
              4'h0: alu_req.op = ALU_MOV;
              4'h1: alu_req.op = ALU_OR;
              4'h2: alu_req.op = ALU_AND;
              4'h3: alu_req.op = ALU_XOR;
              4'h4: alu_req.op = ALU_ADD;
              4'h5: alu_req.op = ALU_SUB;
              4'h6: alu_req.op = ALU_SHR;
              4'h7: begin alu_req.op = ALU_SUB; alu_req.a = vy; alu_req.b = vx; end
              4'hE: alu_req.op = ALU_SHL;
              default: rf_we = 1'b0;
            endcase
          end
          4'hC: begin rf_we = 1'b1; rf_wd = rnd_r & nn; end
          4'hF: begin
            if (nn == 8'h07) begin rf_we = 1'b1; rf_wd = dt; end
            if (nn == 8'h0A) begin rf_we = key_any; rf_wd = {4'h0, key_low}; end
          end
          default: rf_we = 1'b0;
        endcase
      end
      S_VF: begin rf_we = 1'b1; rf_wa = 4'hF; rf_wd = tmp; end
      S_CLS: begin fb_we = 1'b1; fb_wa = cnt[RAW-1:0]; end
      S_DR_RD: begin
        mem_ra = idx_cnt;
        if (cnt == {1'b0, n}) begin rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'b0, hit}; end
      end
      S_DR_WR: begin fb_we = 1'b1; fb_wd = fb_q ^ spr_mask; end
      S_BCD_H: begin
        alu_req.op = ALU_SUB; alu_req.a = tmp; alu_req.b = 8'd100;
        mem_we = !alu_rsp.flag; mem_wd = {4'h0, dig};
      end
      S_BCD_T: begin
        alu_req.op = ALU_SUB; alu_req.a = tmp; alu_req.b = 8'd10;
        mem_we = !alu_rsp.flag; mem_wa = idx + ADDR_W'(1); mem_wd = {4'h0, dig};
      end
      S_BCD_O: begin mem_we = 1'b1; mem_wa = idx + ADDR_W'(2); mem_wd = tmp; end
      S_ST_RD: rf_ra = cnt[3:0];
      S_ST_WR: begin mem_we = 1'b1; mem_wa = idx_cnt; mem_wd = rf_q; end
      S_LD_RD: mem_ra = idx_cnt;
      S_LD_WR: begin rf_we = 1'b1; rf_wa = cnt[3:0]; rf_wd = mem_q; end
      default: mem_we = 1'b0;
    endcase
  end

  // Architectural state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      pc      <= PROG_START;
      idx     <= '0;
      sp      <= '0;
      dt      <= 8'h00;
      st      <= 8'h00;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_CLR: clr_cnt <= clr_cnt + MAW'(1);
        S_IDLE: begin
          if (accept) begin
            kind    <= kind_t'(req.opcode);
            addr_r  <= req.address;
            data_r  <= req.data;
            keys_r  <= req.keys;
            rnd_r   <= req.random_byte;
            drew    <= 1'b0;
            waiting <= 1'b0;
            fault   <= FAULT_NONE;
            rv      <= 8'h00;
          end
        end
        S_RDMEM: rv <= mem_q;
        S_RDPIX: rv <= {7'b0, fb_q[addr_r[CAW-1:0]]};
        S_FHI:   op[15:8] <= mem_q;
        S_FLO:   op[7:0] <= mem_q;
        S_RVX:   vx <= rf_q;
        S_RVY:   vy <= rf_q;
        S_EXEC: begin
          pc  <= pc2;
          cnt <= '0;
          hit <= 1'b0;
          case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) drew <= 1'b1;
              else if (op == 16'h00EE) begin
                if (sp == '0) fault <= FAULT_UNDER;
                else sp <= sp_dec;
              end else fault <= FAULT_UNKNOWN;
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sp >= SPW'(STACK_DEPTH)) fault <= FAULT_OVER;
              else begin
                sp <= sp + SPW'(1);
                pc <= nnn;
              end
            end
            4'h3: if (alu_rsp.eq) pc <= pc4;
            4'h4: if (!alu_rsp.eq) pc <= pc4;
            4'h5: begin
              if (n != 4'h0) fault <= FAULT_UNKNOWN;
              else if (alu_rsp.eq) pc <= pc4;
            end
            4'h8: begin
              if (n inside {4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
                tmp <= {7'b0, alu_rsp.flag};
              end else fault <= FAULT_UNKNOWN;
            end
            4'h9: begin
              if (n != 4'h0) fault <= FAULT_UNKNOWN;
              else if (!alu_rsp.eq) pc <= pc4;
            end
            4'hA: idx <= nnn;
            4'hB: pc <= nnn + ADDR_W'(vx);
            4'hD: drew <= 1'b1;
            4'hE: begin
              if (nn == 8'h9E) begin
                if (key_bit) pc <= pc4;
              end else if (nn == 8'hA1) begin
                if (!key_bit) pc <= pc4;
              end else fault <= FAULT_UNKNOWN;
            end
            4'hF: begin
              case (nn)
                8'h07, 8'h55, 8'h65: ;
                8'h0A: begin
                  if (!key_any) begin
                    waiting <= 1'b1;
                    pc      <= pc;
                  end
                end
                8'h15: dt <= vx;
                8'h18: st <= vx;
                8'h1E: idx <= idx + ADDR_W'(vx);
                8'h29: idx <= FONT_BASE + ADDR_W'({vx[3:0], 2'b00}) + ADDR_W'(vx[3:0]);
                8'h33: begin
                  tmp <= vx;
                  dig <= 4'h0;
                end
                default: fault <= FAULT_UNKNOWN;
              endcase
            end
            default: ;
          endcase
        end
        S_RET:   pc <= stk_q;
        S_CLS:   cnt <= cnt + 5'd1;
        S_DR_FB: tmp <= mem_q;
        S_DR_WR: begin
          hit <= hit | (|(fb_q & spr_mask));
          cnt <= cnt + 5'd1;
        end
        S_BCD_H, S_BCD_T: begin
          if (alu_rsp.flag) begin
            tmp <= alu_rsp.res;
            dig <= dig + 4'd1;
          end else dig <= 4'h0;
        end
        S_ST_WR, S_LD_WR: cnt <= cnt + 5'd1;
        S_FIN: begin
          if (dt != 8'h00) dt <= dt - 8'd1;
          if (st != 8'h00) st <= st - 8'd1;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.pc          <= pc;
            rsp.index_reg   <= idx;
            rsp.draw_flag   <= drew;
            rsp.sound_on    <= (st != 8'h00);
            rsp.waiting_key <= waiting;
            rsp.read_value  <= rv;
            rsp.fault       <= fault;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/c8_checker.sv =====
// Port-level checks of the CHIP-8 core, bound to chip8_cpu_core.
// Depends on c8_pkg and chip8_cpu_core_macros.svh.
`include "chip8_cpu_core_macros.svh"

module c8_checker import c8_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_pc,
  input logic        out_draw,
  input logic        out_wait,
  input logic [7:0]  out_rv,
  input logic [1:0]  out_fault
);

  // Only one request is in the core at a time.
  `C8_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready, "request taken while busy")

  // Execute results that draw, wait for a key or fault never carry read data.
  `C8_ASSERT_IMP(a_exec_no_read, out_valid && (out_draw || out_wait || out_fault != FAULT_NONE), out_rv == 8'h00, "read value on an execute result")

  // A key wait neither draws nor faults.
  `C8_ASSERT_IMP(a_wait_clean, out_valid && out_wait, !out_draw && out_fault == FAULT_NONE, "key wait with draw or fault")

  `C8_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pc), "stalled result changed")

endmodule

bind chip8_cpu_core c8_checker u_c8_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .out_pc(rsp.pc), .out_draw(rsp.draw_flag), .out_wait(rsp.waiting_key),
  .out_rv(rsp.read_value), .out_fault(rsp.fault)
);

// ===== tb/chip8_tb_scoreboard.sv =====
// Scoreboard for the CHIP-8 core bench: a software copy of the processor that
// predicts each result and a queue of pending results. Depends on c8_pkg.
import c8_pkg::*;

typedef struct packed {
  logic [11:0] pc;
  logic [11:0] index_reg;
  logic        draw_flag;
  logic        sound_on;
  logic        waiting_key;
  logic [7:0]  read_value;
  logic [1:0]  fault;
} c8_result_t;

class chip8_scoreboard;
  logic [7:0]  mem [MEM_BYTES];
  logic        fb [SCREEN_W*SCREEN_H];
  logic [7:0]  v [16];
  logic [11:0] idx;
  logic [11:0] pc;
  int          sp;
  logic [11:0] stk [STACK_DEPTH_DEF];
  logic [7:0]  delay_cnt;
  logic [7:0]  sound_cnt;
  c8_result_t  pending [$];
  int          errors;

  function void reset_state();
    for (int i = 0; i < MEM_BYTES; i++) mem[i] = 8'h00;
    for (int i = 0; i < FONT_BYTES; i++) mem[FONT_BASE + i] = FONT[i];
    for (int i = 0; i < SCREEN_W*SCREEN_H; i++) fb[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      v[i] = 8'h00;
      stk[i] = 12'h000;
    end
    idx = 12'h000;
    pc = PROG_START;
    sp = 0;
    delay_cnt = 8'h00;
    sound_cnt = 8'h00;
    errors = 0;
  endfunction

  // Runs one instruction and returns the fault code.
  function fault_t run_instr(logic [15:0] keys, logic [7:0] rnd, output logic drew,
                             output logic waiting);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, nxt, skp;
    logic [8:0]  sum;
    logic [7:0]  bits;
    logic        hit, t;
    fault_t      f;
    int          r, c, py, px, k;
    op = {mem[pc], mem[pc + 12'd1]};
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    nxt = pc + 12'd2;
    skp = pc + 12'd4;
    vx = v[x];
    vy = v[y];
    f = FAULT_NONE;
    drew = 1'b0;
    waiting = 1'b0;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int i = 0; i < SCREEN_W*SCREEN_H; i++) fb[i] = 1'b0;
          drew = 1'b1;
          pc = nxt;
        end else if (op == 16'h00EE) begin
          if (sp == 0) begin
            f = FAULT_UNDER;
            pc = nxt;
          end else begin
            sp--;
            pc = stk[sp];
          end
        end else begin
          f = FAULT_UNKNOWN;
          pc = nxt;
        end
      end
      4'h1: pc = nnn;
      4'h2: begin
        if (sp >= STACK_DEPTH_DEF) begin
          f = FAULT_OVER;
          pc = nxt;
        end else begin
          stk[sp] = nxt;
          sp++;
          pc = nnn;
        end
      end
      4'h3: pc = (vx == nn) ? skp : nxt;
      4'h4: pc = (vx != nn) ? skp : nxt;
      4'h5, 4'h9: begin
        if (n != 0) begin
          f = FAULT_UNKNOWN;
          pc = nxt;
        end else pc = ((vx == vy) ^ (op[15:12] == 4'h9)) ? skp : nxt;
      end
      4'h6: begin v[x] = nn; pc = nxt; end
      4'h7: begin v[x] = vx + nn; pc = nxt; end
      4'h8: begin
        pc = nxt;
        case (n)
          4'h0: v[x] = vy;
          4'h1: v[x] = vx | vy;
          4'h2: v[x] = vx & vy;
          4'h3: v[x] = vx ^ vy;
          4'h4: begin sum = vx + vy; v[x] = sum[7:0]; v[15] = {7'd0, sum[8]}; end
          4'h5: begin v[x] = vx - vy; v[15] = {7'd0, vx >= vy}; end
          4'h6: begin v[x] = vx >> 1; v[15] = {7'd0, vx[0]}; end
          4'h7: begin v[x] = vy - vx; v[15] = {7'd0, vy >= vx}; end
          4'hE: begin v[x] = vx << 1; v[15] = {7'd0, vx[7]}; end
          default: f = FAULT_UNKNOWN;
        endcase
      end
      4'hA: begin idx = nnn; pc = nxt; end
      4'hB: pc = nnn + {4'h0, v[0]};
      4'hC: begin v[x] = rnd & nn; pc = nxt; end
      4'hD: begin
        hit = 1'b0;
        for (r = 0; r < n; r++) begin
          bits = mem[idx + 12'(r)];
          py = (vy % SCREEN_H + r) % SCREEN_H;
          for (c = 0; c < 8; c++) begin
            if (bits[7-c]) begin
              px = (vx % SCREEN_W + c) % SCREEN_W;
              if (fb[py*SCREEN_W + px]) hit = 1'b1;
              fb[py*SCREEN_W + px] = ~fb[py*SCREEN_W + px];
            end
          end
        end
        v[15] = {7'd0, hit};
        drew = 1'b1;
        pc = nxt;
      end
      4'hE: begin
        t = keys[vx[3:0]];
        if (nn == 8'h9E) pc = t ? skp : nxt;
        else if (nn == 8'hA1) pc = t ? nxt : skp;
        else begin
          f = FAULT_UNKNOWN;
          pc = nxt;
        end
      end
      default: begin
        pc = nxt;
        case (nn)
          8'h07: v[x] = delay_cnt;
          8'h0A: begin
            k = 16;
            for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
            if (k < 16) v[x] = 8'(k);
            else begin
              waiting = 1'b1;
              pc = pc - 12'd2;
            end
          end
          8'h15: delay_cnt = vx;
          8'h18: sound_cnt = vx;
          8'h1E: idx = idx + {4'h0, vx};
          8'h29: idx = FONT_BASE + 12'd5 * {8'h0, vx[3:0]};
          8'h33: begin
            mem[idx] = vx / 100;
            mem[idx + 12'd1] = (vx / 10) % 10;
            mem[idx + 12'd2] = vx % 10;
          end
          8'h55: for (int i = 0; i <= x; i++) mem[idx + 12'(i)] = v[i];
          8'h65: for (int i = 0; i <= x; i++) v[i] = mem[idx + 12'(i)];
          default: f = FAULT_UNKNOWN;
        endcase
      end
    endcase
    return f;
  endfunction

  function void note_request(kind_t kind, logic [11:0] addr, logic [7:0] data,
                             logic [15:0] keys, logic [7:0] rnd);
    c8_result_t res;
    logic       drew, waiting;
    fault_t     f;
    res = '0;
    case (kind)
      KIND_LOAD: mem[addr] = data;
      KIND_EXEC: begin
        f = run_instr(keys, rnd, drew, waiting);
        if (delay_cnt != 0) delay_cnt--;
        if (sound_cnt != 0) sound_cnt--;
        res.draw_flag = drew;
        res.waiting_key = waiting;
        res.fault = f;
      end
      KIND_READ: res.read_value = mem[addr];
      default: res.read_value = {7'd0, fb[addr[10:0]]};
    endcase
    res.pc = pc;
    res.index_reg = idx;
    res.sound_on = (sound_cnt != 0);
    pending.push_back(res);
  endfunction

  function void check_result(c8_result_t got);
    c8_result_t exp;
    if (pending.size() == 0) begin
      $error("result with no request pending");
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.pc !== exp.pc) begin
      $error("pc expected %h got %h", exp.pc, got.pc); errors++;
    end
    if (got.index_reg !== exp.index_reg) begin
      $error("index_reg expected %h got %h", exp.index_reg, got.index_reg); errors++;
    end
    if (got.draw_flag !== exp.draw_flag) begin
      $error("draw_flag expected %b got %b", exp.draw_flag, got.draw_flag); errors++;
    end
    if (got.sound_on !== exp.sound_on) begin
      $error("sound_on expected %b got %b", exp.sound_on, got.sound_on); errors++;
    end
    if (got.waiting_key !== exp.waiting_key) begin
      $error("waiting_key expected %b got %b", exp.waiting_key, got.waiting_key);
      errors++;
    end
    if (got.read_value !== exp.read_value) begin
      $error("read_value expected %h got %h", exp.read_value, got.read_value); errors++;
    end
    if (got.fault !== exp.fault) begin
      $error("fault expected %d got %d", exp.fault, got.fault); errors++;
    end
  endfunction
endclass

// ===== tb/tb.sv =====
// Top-level bench for chip8_cpu_core: loads short programs, steps them with random
// keys and idling, and checks every result against the scoreboard. Depends on c8_pkg.
module tb;
  import c8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int   idle_cycles = 0;
  chip8_scoreboard sb = new();

  c8_req_if req();
  c8_rsp_if rsp();

  chip8_cpu_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #5 clk = ~clk;

  // The receiver stalls in random bursts until the quiet part of the run.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        sb.check_result({rsp.pc, rsp.index_reg, rsp.draw_flag, rsp.sound_on,
                         rsp.waiting_key, rsp.read_value, rsp.fault});
      end
      rsp.ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The request stays valid after acceptance until the next one replaces it or an
  // idle burst drops it; the core is busy in between, so nothing is taken twice.
  task automatic send_request(kind_t kind, logic [11:0] addr, logic [7:0] data,
                              logic [15:0] keys, logic [7:0] rnd);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= kind;
    req.address <= addr;
    req.data <= data;
    req.keys <= keys;
    req.random_byte <= rnd;
    do @(posedge clk); while (!req.ready);
    sb.note_request(kind, addr, data, keys, rnd);
  endtask

  task automatic exec_step(logic [15:0] keys);
    send_request(KIND_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom));
  endtask

  // Writes an instruction at the current pc, then runs it.
  task automatic run_op(logic [15:0] op, logic [15:0] keys);
    send_request(KIND_LOAD, sb.pc, op[15:8], 16'($urandom), 8'($urandom));
    send_request(KIND_LOAD, sb.pc + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    exec_step(keys);
  endtask

  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    logic [3:0]  sel;
    op = 16'($urandom);
    sel = 4'($urandom);
    case ($urandom_range(0, 9))
      0: op[7:0] = sel[0] ? 8'h55 : 8'h65;
      1: op[7:0] = {4'h1, sel[1] ? 4'h5 : 4'h8};
      2: op[7:0] = sel[0] ? 8'h33 : 8'h29;
      3: op[7:0] = sel[0] ? 8'h1E : 8'h0A;
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0: op[15:12] = 4'hF;
      1: op[15:12] = 4'h8;
      2: op[15:12] = 4'hD;
      3: op = sel[0] ? 16'h00EE : 16'h00E0;
      4: op[3:0] = sel[1] ? 4'h0 : sel;
      default: ;
    endcase
    if (op[15:12] == 4'hD) op[3:0] = 4'($urandom_range(0, 4));
    return op;
  endfunction

  initial begin
    logic [15:0] op;
    logic [15:0] directed [$];
    req.valid = 1'b0;
    req.opcode = KIND_LOAD;
    req.address = '0;
    req.data = '0;
    req.keys = '0;
    req.random_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    sb.reset_state();
    directed = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8015, 16'h8107, 16'h8016,
                 16'h801E, 16'h8008, 16'h00E0, 16'hA000, 16'hD01F, 16'hD010,
                 16'hF029, 16'hF033, 16'hFF55, 16'hFF65, 16'hF018, 16'hF00A,
                 16'h00EE, 16'h5121, 16'hE09E, 16'hF11E, 16'hC0AA};
    foreach (directed[i]) run_op(directed[i], (i == 17) ? 16'h0000 : 16'hFFFF);
    run_op(16'hF00A, 16'h8000);
    send_request(KIND_READ, 12'hFFF, 8'h00, 16'h0, 8'h0);
    send_request(KIND_PIXEL, 12'hFFF, 8'h00, 16'h0, 8'h0);
    // Fill the stack past its depth.
    for (int i = 0; i < 18; i++) run_op({4'h2, 12'h300 + 12'(i*4)}, 16'h0);
    req.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    for (int i = 0; i < 170; i++) begin
      if (i == 140) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: send_request(KIND_READ, 12'($urandom), 8'h00, 16'($urandom), 8'h0);
        1: send_request(KIND_PIXEL, 12'($urandom), 8'h00, 16'($urandom), 8'h0);
        2: send_request(KIND_LOAD, 12'($urandom), 8'($urandom), 16'($urandom), 8'h0);
        3: exec_step($urandom_range(0, 1) ? 16'($urandom) : 16'h0);
        default: begin
          op = rand_op();
          run_op(op, $urandom_range(0, 2) ? 16'($urandom) : 16'h0);
        end
      endcase
    end
    req.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/c8_pkg.sv
rtl/c8_req_if.sv
rtl/c8_rsp_if.sv
rtl/c8_ram.sv
rtl/c8_alu.sv
rtl/chip8_cpu_core.sv
rtl/c8_checker.sv
tb/chip8_tb_scoreboard.sv
tb/tb.sv
